>>> hdl/ptlaik_pkg.sv
// ----------------------------------------------------------------------------
// ptlaik_pkg
// Shared types, register codes, fixed-point constants and the CORDIC arctangent
// table for the two-link planar arm inverse kinematics block.
// ----------------------------------------------------------------------------
package ptlaik_pkg;

  typedef struct packed {
    logic signed [15:0] target_reach;
    logic signed [15:0] target_height;
  } target_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
  } angles_t;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_LINK    = 8'd0,
    REG_LOWER_LINK    = 8'd1,
    REG_SHOULDER_OFFS = 8'd2,
    REG_ELBOW_OFFS    = 8'd3
  } cfg_reg_t;

  localparam logic [14:0] UPPER_LINK_RESET    = 15'd3798;
  localparam logic [14:0] LOWER_LINK_RESET    = 15'd4424;
  localparam logic [12:0] SHOULDER_OFFS_RESET = 13'd894;
  localparam logic [12:0] ELBOW_OFFS_RESET    = 13'd1035;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ANG_W            = 34;
  localparam longint ANGLE_PI     = 64'd2147483648;

  localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
  localparam logic [60:0] Q60_ONE         = 61'h1000_0000_0000_0000;
  localparam int          RIGHT_ANGLE_DEG = 5760;
  localparam int          DEG_SCALE       = 45;
  localparam int          DEG_SHIFT       = 23;

  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/planar_two_link_arm_ik.sv
// ----------------------------------------------------------------------------
// planar_two_link_arm_ik
// Two-link planar arm inverse kinematics: target (reach, height) in, shoulder
// and elbow servo angles out, fully pipelined.
//
// Command channel: a target beat is taken at a rising edge with start high and
// busy low. busy is low except during reset, so one target can enter every
// cycle. Each result beat shows on result for one cycle with result_valid high;
// the receiver takes it at the end of that cycle and cannot stall the block.
// In order, the pipeline holds stages of squaring, clamping and numerator
// setup, the one-bit-per-stage divider for the law-of-cosines value, stages
// that form 1 - c^2, the one-bit-per-stage square root, link product stages,
// the fold and micro-rotation stages of the three parallel CORDIC vectoring
// units and stages of angle sum, degree scaling and offsets. Throughput is
// one target per cycle.
// Configuration: cfg_valid/cfg_ready writes the link lengths and mount
// offsets by index; cfg_ready is always high and unknown indexes are dropped.
// Write configuration only while no target is in flight.
// Reset clears the pipeline valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module planar_two_link_arm_ik #(
  parameter int CORDIC_STEPS = ptlaik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  ptlaik_pkg::target_t                 target,
  output logic                                result_valid,
  output ptlaik_pkg::angles_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptlaik_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptlaik_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ptlaik_pkg::*;

  localparam int QUOT_W = 30;
  localparam int DEN_W  = 32;
  localparam int ROOT_W = 31;
  localparam int CA_W   = 34;
  localparam int CB_W   = 36;
  localparam int CC_W   = 50;
  localparam int DIV_TAG_W = 35;
  localparam int SQ_TAG_W  = 64;

  // configuration registers
  logic [14:0] upper_len;
  logic [14:0] lower_len;
  logic [12:0] shoulder_offs;
  logic [12:0] elbow_offs;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len     <= UPPER_LINK_RESET;
      lower_len     <= LOWER_LINK_RESET;
      shoulder_offs <= SHOULDER_OFFS_RESET;
      elbow_offs    <= ELBOW_OFFS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_LINK:    upper_len     <= cfg_data[14:0];
        REG_LOWER_LINK:    lower_len     <= cfg_data[14:0];
        REG_SHOULDER_OFFS: shoulder_offs <= cfg_data[12:0];
        REG_ELBOW_OFFS:    elbow_offs    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // link geometry derived from configuration
  logic [29:0] l1sq;
  logic [29:0] l2sq;
  logic [31:0] lsumsq;
  logic [29:0] ldiffsq;
  logic [29:0] l1l2;
  logic [30:0] nsum;
  logic [DEN_W-1:0] den;
  logic [31:0] maxsq;
  logic [31:0] minsq;
  logic [15:0] lsum;
  logic [14:0] ldiff;

  assign lsum  = {1'b0, upper_len} + {1'b0, lower_len};
  assign ldiff = (upper_len >= lower_len) ? upper_len - lower_len : lower_len - upper_len;

  always_ff @(posedge clk) begin
    l1sq    <= upper_len * upper_len;
    l2sq    <= lower_len * lower_len;
    lsumsq  <= lsum * lsum;
    ldiffsq <= ldiff * ldiff;
    l1l2    <= upper_len * lower_len;
    nsum    <= {1'b0, l1sq} + {1'b0, l2sq};
    den     <= {1'b0, l1l2, 1'b0};
    maxsq   <= lsumsq;
    minsq   <= {2'b0, ldiffsq};
  end

  // front pipeline stages
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic signed [15:0] x1, y1, x2, y2, x3, y3, x4, y4, x5, y5;
  logic signed [15:0] x6, y6, x7, y7, x8, y8, x9, y9;
  logic signed [31:0] sq_x, sq_y;
  logic [30:0] xx1, yy1;
  logic [31:0] rsq2;
  logic [31:0] rc3;
  logic signed [33:0] num;
  logic [32:0] mag4;
  logic neg4;
  logic [DEN_W-1:0] rem5;
  logic neg5, ovf5, dz5;

  assign sq_x = target.target_reach * target.target_reach;
  assign sq_y = target.target_height * target.target_height;
  assign num  = $signed({3'b0, nsum}) - $signed({2'b0, rc3});

  always_ff @(posedge clk) begin
    x1   <= target.target_reach;
    y1   <= target.target_height;
    xx1  <= sq_x[30:0];
    yy1  <= sq_y[30:0];
    x2   <= x1;
    y2   <= y1;
    rsq2 <= {1'b0, xx1} + {1'b0, yy1};
    x3   <= x2;
    y3   <= y2;
    if (rsq2 > maxsq) begin
      rc3 <= maxsq;
    end else if ((rsq2 != '0) && (rsq2 < minsq)) begin
      rc3 <= minsq;
    end else begin
      rc3 <= rsq2;
    end
    x4   <= x3;
    y4   <= y3;
    neg4 <= num[33];
    mag4 <= num[33] ? 33'(-num) : num[32:0];
    x5   <= x4;
    y5   <= y4;
    neg5 <= neg4;
    dz5  <= (den == '0);
    ovf5 <= (den == '0) || (mag4 >= {1'b0, den});
    rem5 <= ((den == '0) || (mag4 >= {1'b0, den})) ? '0 : mag4[DEN_W-1:0];
  end

  // law-of-cosines division
  logic                 dv_valid;
  logic [QUOT_W-1:0]    dv_quot;
  logic [DIV_TAG_W-1:0] dv_tag;

  ptlaik_divider #(
    .QUOT_W(QUOT_W),
    .DEN_W (DEN_W),
    .TAG_W (DIV_TAG_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .in_rem   (rem5),
    .den      (den),
    .in_tag   ({x5, y5, neg5, ovf5, dz5}),
    .out_valid(dv_valid),
    .out_quot (dv_quot),
    .out_tag  (dv_tag)
  );

  logic [30:0] q6, q7, q8, q9;
  logic        cneg6, cneg7, cneg8, cneg9;
  logic [61:0] q2_7;
  logic [60:0] rad8;

  always_ff @(posedge clk) begin
    x6    <= dv_tag[34:19];
    y6    <= dv_tag[18:3];
    cneg6 <= dv_tag[2] && !dv_tag[0];
    q6    <= dv_tag[1] ? Q30_ONE : {1'b0, dv_quot};
    x7    <= x6;
    y7    <= y6;
    cneg7 <= cneg6;
    q7    <= q6;
    q2_7  <= q6 * q6;
    x8    <= x7;
    y8    <= y7;
    cneg8 <= cneg7;
    q8    <= q7;
    rad8  <= Q60_ONE - q2_7[60:0];
  end

  // sine from 1 - c^2
  logic                sq_valid;
  logic [ROOT_W-1:0]   sq_root;
  logic [SQ_TAG_W-1:0] sq_tag;

  ptlaik_sqrt #(
    .ROOT_W(ROOT_W),
    .TAG_W (SQ_TAG_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v8),
    .in_rad   ({1'b0, rad8}),
    .in_tag   ({x8, y8, q8, cneg8}),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  logic [30:0] s9;
  logic [45:0] lq9, ls9;
  logic signed [CA_W-1:0] a_px, a_py;
  logic signed [CB_W-1:0] b_px, b_py;
  logic signed [CC_W-1:0] c_px, c_py;
  logic signed [CC_W-1:0] l1_q30;

  assign l1_q30 = $signed({5'b0, upper_len, 30'b0});

  always_ff @(posedge clk) begin
    x9    <= sq_tag[63:48];
    y9    <= sq_tag[47:32];
    q9    <= sq_tag[31:1];
    cneg9 <= sq_tag[0];
    s9    <= sq_root;
    lq9   <= lower_len * sq_tag[31:1];
    ls9   <= lower_len * sq_root;
    a_px  <= cneg9 ? $signed({3'b0, q9}) : -$signed({3'b0, q9});
    a_py  <= $signed({3'b0, s9});
    b_px  <= $signed({{(CB_W-32){x9[15]}}, x9, 16'b0});
    b_py  <= $signed({{(CB_W-32){y9[15]}}, y9, 16'b0});
    c_px  <= cneg9 ? l1_q30 + $signed({4'b0, lq9}) : l1_q30 - $signed({4'b0, lq9});
    c_py  <= $signed({4'b0, ls9});
  end

  // three angle vectoring units
  logic va, vb, vc;
  logic signed [ANG_W-1:0] za, zb, zc;

  ptlaik_cordic #(.DATA_W(CA_W), .STEPS(CORDIC_STEPS)) u_cordic_elbow (
    .clk(clk), .rst(rst), .in_valid(v10), .px(a_px), .py(a_py),
    .out_valid(va), .angle(za)
  );

  ptlaik_cordic #(.DATA_W(CB_W), .STEPS(CORDIC_STEPS)) u_cordic_target (
    .clk(clk), .rst(rst), .in_valid(v10), .px(b_px), .py(b_py),
    .out_valid(vb), .angle(zb)
  );

  ptlaik_cordic #(.DATA_W(CC_W), .STEPS(CORDIC_STEPS)) u_cordic_link (
    .clk(clk), .rst(rst), .in_valid(v10), .px(c_px), .py(c_py),
    .out_valid(vc), .angle(zc)
  );

  // angle sum, degree scaling, offsets
  logic signed [ANG_W:0] th1, th2;
  logic signed [41:0] p1, p2;
  logic signed [18:0] d1, d2;
  logic signed [18:0] sh, el;

  assign p1 = $signed(th1) * 42'sd45 + (42'sd1 <<< (DEG_SHIFT - 1));
  assign p2 = $signed(th2) * 42'sd45 + (42'sd1 <<< (DEG_SHIFT - 1));
  assign sh = 19'(RIGHT_ANGLE_DEG) - d1 - $signed({6'b0, shoulder_offs});
  assign el = d2 + $signed({6'b0, elbow_offs}) - 19'(RIGHT_ANGLE_DEG);

  always_ff @(posedge clk) begin
    th1 <= $signed({zb[ANG_W-1], zb}) + $signed({zc[ANG_W-1], zc});
    th2 <= $signed({za[ANG_W-1], za});
    d1  <= p1[41:DEG_SHIFT];
    d2  <= p2[41:DEG_SHIFT];
    result.shoulder_angle <= sh[15:0];
    result.elbow_angle    <= el[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      v11 <= 1'b0; v12 <= 1'b0; result_valid <= 1'b0;
    end else begin
      v1  <= start && !busy;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= dv_valid;
      v7  <= v6;
      v8  <= v7;
      v9  <= sq_valid;
      v10 <= v9;
      v11 <= va && vb && vc;
      v12 <= v11;
      result_valid <= v12;
    end
  end

  assert property (@(posedge clk) disable iff (rst) v6 |-> (q6 <= Q30_ONE))
    else $error("cosine magnitude above one");

  assert property (@(posedge clk) disable iff (rst) v7 |-> (q2_7 <= {1'b0, Q60_ONE}))
    else $error("cosine square wraps the sine radicand");

  assert property (@(posedge clk) disable iff (rst) v9 |-> (s9 <= Q30_ONE))
    else $error("sine magnitude above one");

  assert property (@(posedge clk) disable iff (rst) (va == vb) && (vb == vc))
    else $error("vectoring units out of step");

endmodule

>>> hdl/ptlaik_divider.sv
// ----------------------------------------------------------------------------
// ptlaik_divider
// Pipelined restoring divider: one quotient bit per stage. Gives
// floor(rem * 2^QUOT_W / den) for rem < den, with a tag riding alongside.
// ----------------------------------------------------------------------------
module ptlaik_divider #(
  parameter int QUOT_W = 30,
  parameter int DEN_W  = 32,
  parameter int TAG_W  = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [DEN_W-1:0]  den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [QUOT_W-1:0] out_quot,
  output logic [TAG_W-1:0]  out_tag
);

  logic              valid [QUOT_W];
  logic [DEN_W-1:0]  rem [QUOT_W];
  logic [QUOT_W-1:0] quot [QUOT_W];
  logic [TAG_W-1:0]  tag [QUOT_W];

  logic [DEN_W-1:0]  rem_next [QUOT_W];
  logic [QUOT_W-1:0] quot_next [QUOT_W];

  always_comb begin
    logic [DEN_W-1:0]  src_rem;
    logic [QUOT_W-1:0] src_quot;
    logic [DEN_W:0]    dbl;
    logic [DEN_W:0]    dext;
    for (int k = 0; k < QUOT_W; k++) begin
      src_rem  = (k == 0) ? in_rem : rem[(k == 0) ? 0 : k-1];
      src_quot = (k == 0) ? '0 : quot[(k == 0) ? 0 : k-1];
      dbl  = {src_rem, 1'b0};
      dext = {1'b0, den};
      if (dbl >= dext) begin
        rem_next[k]  = DEN_W'(dbl - dext);
        quot_next[k] = {src_quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = dbl[DEN_W-1:0];
        quot_next[k] = {src_quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUOT_W; k++) valid[k] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int k = 1; k < QUOT_W; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUOT_W; k++) begin
      rem[k]  <= rem_next[k];
      quot[k] <= quot_next[k];
    end
    tag[0] <= in_tag;
    for (int k = 1; k < QUOT_W; k++) tag[k] <= tag[k-1];
  end

  assign out_valid = valid[QUOT_W-1];
  assign out_quot  = quot[QUOT_W-1];
  assign out_tag   = tag[QUOT_W-1];

endmodule

>>> hdl/ptlaik_sqrt.sv
// ----------------------------------------------------------------------------
// ptlaik_sqrt
// Pipelined digit-by-digit integer square root: one root bit per stage,
// floor result, with a tag riding alongside.
// ----------------------------------------------------------------------------
module ptlaik_sqrt #(
  parameter int ROOT_W = 31,
  parameter int TAG_W  = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              valid [ROOT_W];
  logic [RAD_W-1:0]  rad [ROOT_W];
  logic [REM_W-1:0]  rem [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [TAG_W-1:0]  tag [ROOT_W];

  logic [RAD_W-1:0]  rad_next [ROOT_W];
  logic [REM_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];

  always_comb begin
    logic [RAD_W-1:0]  src_rad;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < ROOT_W; k++) begin
      src_rad  = (k == 0) ? in_rad : rad[(k == 0) ? 0 : k-1];
      src_rem  = (k == 0) ? '0 : rem[(k == 0) ? 0 : k-1];
      src_root = (k == 0) ? '0 : root[(k == 0) ? 0 : k-1];
      shifted  = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      trial    = REM_W'({src_root, 2'b01});
      rad_next[k] = {src_rad[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_next[k]  = shifted - trial;
        root_next[k] = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = shifted;
        root_next[k] = {src_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) valid[k] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int k = 1; k < ROOT_W; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      rad[k]  <= rad_next[k];
      rem[k]  <= rem_next[k];
      root[k] <= root_next[k];
    end
    tag[0] <= in_tag;
    for (int k = 1; k < ROOT_W; k++) tag[k] <= tag[k-1];
  end

  assign out_valid = valid[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule

>>> hdl/ptlaik_cordic.sv
// ----------------------------------------------------------------------------
// ptlaik_cordic
// Pipelined CORDIC vectoring unit: a half-plane fold stage, then one
// micro-rotation per stage. Gives atan2(py, px) with pi = 2^31.
// ----------------------------------------------------------------------------
module ptlaik_cordic #(
  parameter int DATA_W = 36,
  parameter int STEPS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [DATA_W-1:0]             px,
  input  logic signed [DATA_W-1:0]             py,
  output logic                                 out_valid,
  output logic signed [ptlaik_pkg::ANG_W-1:0]  angle
);

  import ptlaik_pkg::*;

  localparam logic signed [ANG_W-1:0] PI_ANG = ANG_W'(ANGLE_PI);

  logic                    valid [STEPS+1];
  logic                    zero [STEPS+1];
  logic signed [DATA_W-1:0] x [STEPS+1];
  logic signed [DATA_W-1:0] y [STEPS+1];
  logic signed [ANG_W-1:0]  z [STEPS+1];

  logic signed [DATA_W-1:0] x_next [STEPS+1];
  logic signed [DATA_W-1:0] y_next [STEPS+1];
  logic signed [ANG_W-1:0]  z_next [STEPS+1];
  logic                     zero_next;

  always_comb begin
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic signed [ANG_W-1:0]  sz;
    logic signed [ANG_W-1:0]  step_ang;
    zero_next = (px == '0) && (py == '0);
    if (px < 0) begin
      x_next[0] = -px;
      y_next[0] = -py;
      z_next[0] = (py < 0) ? -PI_ANG : PI_ANG;
    end else begin
      x_next[0] = px;
      y_next[0] = py;
      z_next[0] = '0;
    end
    for (int k = 1; k <= STEPS; k++) begin
      sx = x[k-1];
      sy = y[k-1];
      sz = z[k-1];
      step_ang = $signed(ANG_W'(atan_entry(k-1)));
      if (sy > 0) begin
        x_next[k] = sx + (sy >>> (k-1));
        y_next[k] = sy - (sx >>> (k-1));
        z_next[k] = sz + step_ang;
      end else begin
        x_next[k] = sx - (sy >>> (k-1));
        y_next[k] = sy + (sx >>> (k-1));
        z_next[k] = sz - step_ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) valid[k] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int k = 1; k <= STEPS; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= STEPS; k++) begin
      x[k] <= x_next[k];
      y[k] <= y_next[k];
      z[k] <= z_next[k];
    end
    zero[0] <= zero_next;
    for (int k = 1; k <= STEPS; k++) zero[k] <= zero[k-1];
  end

  assign out_valid = valid[STEPS];
  assign angle     = zero[STEPS] ? '0 : z[STEPS];

endmodule

>>> tb/ik_angle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ik_angle_checker
// Watches the target, result and configuration channels of the two-link arm
// inverse kinematics block, predicts the servo angles of every accepted target
// from its own copy of the link lengths and mount offsets, and compares each
// result beat field by field with the oldest predicted pair.
// ----------------------------------------------------------------------------
module ik_angle_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  ptlaik_pkg::target_t               target,
  input  logic                              result_valid,
  input  ptlaik_pkg::angles_t               result,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ptlaik_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptlaik_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                mismatches,
  output int                                outstanding,
  output int                                results_seen
);

  import ptlaik_pkg::*;

  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint ONE_Q30   = 64'sd1073741824;

  longint atan_steps [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [14:0] upper_len, lower_len;
  logic [12:0] shoulder_offs, elbow_offs;
  angles_t     expected_angles[$];

  assign outstanding = expected_angles.size();

  function automatic longint vector_heading(longint px, longint py);
    longint z, dx, dy;
    z = 0;
    if (px == 0 && py == 0) return 0;
    if (px < 0) begin
      z  = (py < 0) ? -HALF_TURN : HALF_TURN;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py > 0) begin
        px += dx;
        py -= dy;
        z  += atan_steps[i];
      end else begin
        px -= dx;
        py += dy;
        z  -= atan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned rem, res, bitv;
    rem  = v;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint to_sixtyfourths(longint a);
    return (a * 45 + (64'sd1 << 22)) >>> 23;
  endfunction

  function automatic angles_t solve_arm(target_t t);
    longint x, y, l1, l2, rsq, maxsq, minsq, num, c, s, th1, th2, sh, el;
    longint unsigned mag, den, q;
    angles_t a;
    x     = longint'(t.target_reach);
    y     = longint'(t.target_height);
    l1    = longint'(upper_len);
    l2    = longint'(lower_len);
    rsq   = x * x + y * y;
    maxsq = (l1 + l2) * (l1 + l2);
    minsq = (l1 - l2) * (l1 - l2);
    if (rsq > maxsq) rsq = maxsq;
    if (rsq > 0 && rsq < minsq) rsq = minsq;
    num = l1 * l1 + l2 * l2 - rsq;
    den = 2 * l1 * l2;
    if (den == 0) begin
      c = ONE_Q30;
    end else begin
      mag = (num < 0) ? -num : num;
      q   = (mag << 30) / den;
      if (q > ONE_Q30) q = ONE_Q30;
      c = (num < 0) ? -longint'(q) : longint'(q);
    end
    s   = longint'(floor_root(longint'(ONE_Q30 * ONE_Q30) - c * c));
    th2 = vector_heading(-c, s);
    th1 = vector_heading(x * 65536, y * 65536)
        + vector_heading(l1 * ONE_Q30 - l2 * c, l2 * s);
    sh  = RIGHT_ANGLE_DEG - to_sixtyfourths(th1) - longint'(shoulder_offs);
    el  = to_sixtyfourths(th2) + longint'(elbow_offs) - RIGHT_ANGLE_DEG;
    a.shoulder_angle = sh[15:0];
    a.elbow_angle    = el[15:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;
  initial results_seen = 0;

  always @(posedge clk) begin
    angles_t want;
    if (rst) begin
      upper_len     <= UPPER_LINK_RESET;
      lower_len     <= LOWER_LINK_RESET;
      shoulder_offs <= SHOULDER_OFFS_RESET;
      elbow_offs    <= ELBOW_OFFS_RESET;
    end else begin
      if (start && !busy) expected_angles.push_back(solve_arm(target));
      if (result_valid) begin
        results_seen++;
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected beat shoulder_angle", result.shoulder_angle, 0);
        end else begin
          want = expected_angles.pop_front();
          if (result.shoulder_angle !== want.shoulder_angle)
            report_mismatch("shoulder_angle", result.shoulder_angle, want.shoulder_angle);
          if (result.elbow_angle !== want.elbow_angle)
            report_mismatch("elbow_angle", result.elbow_angle, want.elbow_angle);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UPPER_LINK:    upper_len     <= cfg_data[14:0];
          REG_LOWER_LINK:    lower_len     <= cfg_data[14:0];
          REG_SHOULDER_OFFS: shoulder_offs <= cfg_data[12:0];
          REG_ELBOW_OFFS:    elbow_offs    <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives targets into the two-link arm inverse kinematics block under several
// link and offset settings (extremes, zero and equal links), with directed
// corner targets and random ones at three levels of sender idling, and gives
// the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
  import ptlaik_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 8'd7;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 5000;

  logic clk, rst, start, busy, result_valid, cfg_valid, cfg_ready;
  target_t target;
  angles_t result;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int mismatches, outstanding, results_seen, idle_pct, quiet_cycles, targets_sent;

  planar_two_link_arm_ik u_top (
    .clk, .rst, .start, .busy, .target, .result_valid, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ik_angle_checker u_checker (
    .clk, .rst, .start, .busy, .target, .result_valid, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .results_seen
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      target <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    target.target_reach  <= x;
    target.target_height <= y;
    do @(posedge clk); while (busy);
    targets_sent++;
  endtask

  // hold cfg_valid after the beat; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_arm(logic [15:0] l1, logic [15:0] l2, logic [15:0] so, logic [15:0] eo);
    drain();
    write_reg(REG_UPPER_LINK, l1);
    write_reg(REG_LOWER_LINK, l2);
    write_reg(REG_SHOULDER_OFFS, so);
    write_reg(REG_ELBOW_OFFS, eo);
  endtask

  task automatic random_target();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_target(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384));
    else if (pick < 85)
      send_target(16'($urandom), 16'($urandom));
    else
      send_target(16'($urandom_range(128) - 64), 16'($urandom_range(128) - 64));
  endtask

  task automatic corner_targets();
    send_target(16'sd0, 16'sd0);
    send_target(-16'sd5, 16'sd0);
    send_target(16'sd0, 16'sd77);
    send_target(16'sd0, -16'sd77);
    send_target(16'sh7FFF, 16'sh7FFF);
    send_target(16'sh8000, 16'sh8000);
    send_target(16'sd16384, -16'sd16384);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    target = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    targets_sent = 0;
    idle_pct = 9;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    corner_targets();
    send_target(16'sd8222, 16'sd0);
    send_target(16'sd626, 16'sd0);
    send_target(16'sd100, 16'sd50);
    send_target(16'sd5000, 16'sd3000);
    send_target(-16'sd16384, 16'sd16384);
    send_target(-16'sd300, -16'sd7000);

    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 9 : (phase < 4) ? 65 : 0;
      case (phase)
        0: set_arm(16'd1, 16'd1, 16'd0, 16'd0);
        1: set_arm(16'd16384, 16'd16384, 16'd5760, 16'd5760);
        2: set_arm(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: begin
          set_arm(16'd0, 16'd4424, 16'd894, 16'd1035);
          write_reg(UNMAPPED_REG, 16'hFFFF);
        end
        4: set_arm(16'd5000, 16'd5000, 16'($urandom_range(5760)),
                   16'($urandom_range(5760)));
        default: set_arm(16'($urandom_range(16384, 1)), 16'($urandom_range(16384, 1)),
                         16'($urandom_range(5760)), 16'($urandom_range(5760)));
      endcase
      cfg_valid <= 1'b0;
      corner_targets();
      repeat (200) random_target();
    end

    drain();
    $display("Sent %0d targets over seven link/offset settings, %0d result beats checked.",
             targets_sent, results_seen);
    $display("Covered extreme, zero and equal links, full-range and near-origin targets.");
    if (mismatches == 0 && outstanding == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
